@@ src/ipss_pkg.sv @@
// Package for the inverter PWM start-up sequencer.
// Widths, codes and the structs shared by the core, the top level and the checker.
// No dependencies.
package ipss_pkg;

  localparam int TIMER_BITS    = 16;
  localparam int ADC_BITS      = 12;
  localparam int CFG_TICK_BITS = 16;
  localparam int CFG_WIN_BITS  = 12;
  localparam int CMP_BITS      = (TIMER_BITS > CFG_TICK_BITS) ? TIMER_BITS : CFG_TICK_BITS;
  localparam int ADDR_BITS     = 4;
  localparam int DATA_BITS     = 32;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;

  localparam logic [1:0] REG_PUMP_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_CALIB_TICKS  = 2'd1;
  localparam logic [1:0] REG_WIN_LOW      = 2'd2;
  localparam logic [1:0] REG_WIN_HIGH     = 2'd3;

  localparam logic [CFG_TICK_BITS-1:0] RST_PUMP_TIMEOUT = CFG_TICK_BITS'(1000);
  localparam logic [CFG_TICK_BITS-1:0] RST_CALIB_TICKS  = CFG_TICK_BITS'(500);
  localparam logic [ADC_BITS-1:0]      RST_WIN_LOW      = ADC_BITS'(100);
  localparam logic [ADC_BITS-1:0]      RST_WIN_HIGH     = ADC_BITS'(3995);

  localparam logic [1:0] PWM_NONE    = 2'd0;
  localparam logic [1:0] PWM_ENABLE  = 2'd1;
  localparam logic [1:0] PWM_DISABLE = 2'd2;

  localparam logic [3:0] PH_STOP       = 4'd0;
  localparam logic [3:0] PH_PUMP_SETUP = 4'd1;
  localparam logic [3:0] PH_PUMPING    = 4'd2;
  localparam logic [3:0] PH_CALIBRATE  = 4'd3;
  localparam logic [3:0] PH_COMP_SETUP = 4'd4;
  localparam logic [3:0] PH_PRESTART   = 4'd5;
  localparam logic [3:0] PH_START      = 4'd6;
  localparam logic [3:0] PH_RUN        = 4'd7;
  localparam logic [3:0] PH_FAULT      = 4'd8;

  typedef struct packed {
    logic [CFG_TICK_BITS-1:0] pump_timeout_ticks;
    logic [CFG_TICK_BITS-1:0] calibration_ticks;
    logic [ADC_BITS-1:0]      adc_window_low;
    logic [ADC_BITS-1:0]      adc_window_high;
  } ipss_cfg_t;

  typedef struct packed {
    logic [1:0]          mode;
    logic [ADC_BITS-1:0] adc_u;
    logic [ADC_BITS-1:0] adc_v;
    logic [ADC_BITS-1:0] adc_w;
    logic                bus_comp_fault;
  } ipss_item_t;

  typedef struct packed {
    logic [3:0] phase;
    logic       pump_init;
    logic       pump_pulse;
    logic       pump_release;
    logic       calib_begin;
    logic       calib_step;
    logic       oc_comp_start;
    logic       oc_comp_stop;
    logic       bus_comp_count_mode;
    logic [1:0] pwm_command;
    logic       zero_duty;
    logic       pump_timeout;
  } ipss_result_t;

endpackage

@@ src/ipss_window.sv @@
// ADC window check on the three phase current channels.
// Depends on ipss_pkg.
module ipss_window (
  input  logic [ipss_pkg::ADC_BITS-1:0] adc_u,
  input  logic [ipss_pkg::ADC_BITS-1:0] adc_v,
  input  logic [ipss_pkg::ADC_BITS-1:0] adc_w,
  input  logic [ipss_pkg::ADC_BITS-1:0] win_low,
  input  logic [ipss_pkg::ADC_BITS-1:0] win_high,
  output logic                          ok
);
  import ipss_pkg::*;

  logic ok_u;
  logic ok_v;
  logic ok_w;

  assign ok_u = (win_low < adc_u) && (adc_u < win_high);
  assign ok_v = (win_low < adc_v) && (adc_v < win_high);
  assign ok_w = (win_low < adc_w) && (adc_w < win_high);
  assign ok   = ok_u && ok_v && ok_w;

endmodule

@@ src/ipss_core.sv @@
// Phase machine, phase timer and request flags of the start-up sequencer.
// Depends on ipss_pkg and ipss_window.
module ipss_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  ipss_pkg::ipss_item_t  item,
  input  ipss_pkg::ipss_cfg_t   cfg,
  output ipss_pkg::ipss_result_t res
);
  import ipss_pkg::*;

  typedef enum logic [8:0] {
    ST_STOP       = 9'b000000001,
    ST_PUMP_SETUP = 9'b000000010,
    ST_PUMPING    = 9'b000000100,
    ST_CALIBRATE  = 9'b000001000,
    ST_COMP_SETUP = 9'b000010000,
    ST_PRESTART   = 9'b000100000,
    ST_START      = 9'b001000000,
    ST_RUN        = 9'b010000000,
    ST_FAULT      = 9'b100000000
  } state_t;

  state_t                state;
  state_t                state_next;
  logic [TIMER_BITS-1:0] timer;
  logic [TIMER_BITS-1:0] timer_next;
  logic [TIMER_BITS-1:0] timer_inc;
  logic                  start_pending;
  logic                  start_pending_next;
  logic                  stop_pending;
  logic                  stop_pending_next;
  logic                  win_ok;
  logic                  pump_expired;
  logic                  calib_expired;

  ipss_window u_window (
    .adc_u    (item.adc_u),
    .adc_v    (item.adc_v),
    .adc_w    (item.adc_w),
    .win_low  (cfg.adc_window_low),
    .win_high (cfg.adc_window_high),
    .ok       (win_ok)
  );

  assign timer_inc     = (timer == {TIMER_BITS{1'b1}}) ? timer : timer + 1'b1;
  assign pump_expired  = CMP_BITS'(timer_inc) > CMP_BITS'(cfg.pump_timeout_ticks);
  assign calib_expired = CMP_BITS'(timer_inc) > CMP_BITS'(cfg.calibration_ticks);

  always_comb begin
    state_next         = state;
    timer_next         = timer;
    start_pending_next = start_pending;
    stop_pending_next  = stop_pending;
    res                = '0;
    case (item.mode)
      MODE_START: begin
        start_pending_next = 1'b1;
        stop_pending_next  = 1'b0;
      end
      MODE_STOP: begin
        stop_pending_next  = 1'b1;
        start_pending_next = 1'b0;
      end
      MODE_TICK: begin
        case (state)
          ST_STOP: begin
            if (start_pending) begin
              start_pending_next = 1'b0;
              state_next         = ST_PUMP_SETUP;
            end
            res.oc_comp_stop  = 1'b1;
            stop_pending_next = 1'b0;
            timer_next        = '0;
          end
          ST_PUMP_SETUP: begin
            res.pump_init = 1'b1;
            state_next    = ST_PUMPING;
          end
          ST_PUMPING: begin
            if (win_ok) begin
              timer_next      = '0;
              state_next      = ST_CALIBRATE;
              res.calib_begin = 1'b1;
            end else begin
              timer_next = timer_inc;
              if (pump_expired) begin
                state_next       = ST_FAULT;
                res.pump_timeout = 1'b1;
              end else if (item.bus_comp_fault) begin
                state_next = ST_FAULT;
              end else begin
                res.pump_pulse = 1'b1;
              end
            end
          end
          ST_CALIBRATE: begin
            if (stop_pending) begin
              stop_pending_next       = 1'b0;
              state_next              = ST_STOP;
              res.bus_comp_count_mode = 1'b1;
            end else begin
              timer_next     = timer_inc;
              res.calib_step = 1'b1;
              if (item.bus_comp_fault) begin
                state_next = ST_FAULT;
              end else begin
                res.pump_pulse = 1'b1;
                if (calib_expired) begin
                  state_next = ST_COMP_SETUP;
                end
              end
            end
          end
          ST_COMP_SETUP: begin
            if (!win_ok) begin
              state_next = ST_FAULT;
            end else begin
              res.bus_comp_count_mode = 1'b1;
              res.pump_release        = 1'b1;
              res.oc_comp_start       = 1'b1;
              res.pwm_command         = PWM_ENABLE;
              state_next              = ST_PRESTART;
              timer_next              = '0;
            end
          end
          ST_PRESTART: begin
            timer_next     = timer_inc;
            res.zero_duty  = 1'b1;
            res.calib_step = 1'b1;
            if (calib_expired) begin
              state_next = ST_START;
            end
          end
          ST_START: begin
            res.pwm_command = PWM_ENABLE;
            state_next      = ST_RUN;
          end
          ST_RUN: begin
            if (stop_pending) begin
              stop_pending_next = 1'b0;
              state_next        = ST_STOP;
              res.pwm_command   = PWM_DISABLE;
            end
          end
          ST_FAULT: begin
            res.pump_release = 1'b1;
            if (stop_pending) begin
              stop_pending_next       = 1'b0;
              state_next              = ST_STOP;
              res.bus_comp_count_mode = 1'b1;
            end
          end
          default: begin
            state_next = state;
          end
        endcase
      end
      default: begin
        state_next = state;
      end
    endcase

    case (state_next)
      ST_STOP:       res.phase = PH_STOP;
      ST_PUMP_SETUP: res.phase = PH_PUMP_SETUP;
      ST_PUMPING:    res.phase = PH_PUMPING;
      ST_CALIBRATE:  res.phase = PH_CALIBRATE;
      ST_COMP_SETUP: res.phase = PH_COMP_SETUP;
      ST_PRESTART:   res.phase = PH_PRESTART;
      ST_START:      res.phase = PH_START;
      ST_RUN:        res.phase = PH_RUN;
      ST_FAULT:      res.phase = PH_FAULT;
      default:       res.phase = PH_STOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_STOP;
      timer         <= '0;
      start_pending <= 1'b0;
      stop_pending  <= 1'b0;
    end else if (step) begin
      state         <= state_next;
      timer         <= timer_next;
      start_pending <= start_pending_next;
      stop_pending  <= stop_pending_next;
    end
  end

endmodule

@@ src/inverter_pwm_startup_sequencer_top.sv @@
// Top level of the inverter PWM start-up sequencer: input register, APB registers,
// sequencer core and result register. Depends on ipss_pkg and ipss_core.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one item per transfer: mode selects
//   a control tick, a start request or a stop request; ticks use the three ADC
//   readings and the bus comparator fault. Every item yields exactly one result
//   on the output channel (out_valid/out_stall): the phase after the item and
//   the hardware strobes for that tick.
//   Throughput is one item per cycle while the receiver does not stall; the phase
//   machine and timer update in one pass between the input register and the
//   result register.
//   While the receiver stalls, the result register holds and the input register
//   still takes one more item; in_stall rises once both are full.
//   The user must write registers over APB only while the block is idle; the block
//   does not enforce it. pready is always high; reads return the register values.
//   Reset (rst, synchronous) empties both registers, puts the sequencer in the
//   stop phase with timer and request flags clear, and loads the register
//   defaults.
module inverter_pwm_startup_sequencer_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ipss_pkg::ADDR_BITS-1:0] paddr,
  input  logic [ipss_pkg::DATA_BITS-1:0] pwdata,
  output logic [ipss_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     mode,
  input  logic [ipss_pkg::ADC_BITS-1:0]  adc_u,
  input  logic [ipss_pkg::ADC_BITS-1:0]  adc_v,
  input  logic [ipss_pkg::ADC_BITS-1:0]  adc_w,
  input  logic                           bus_comp_fault,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [3:0]                     phase,
  output logic                           pump_init,
  output logic                           pump_pulse,
  output logic                           pump_release,
  output logic                           calib_begin,
  output logic                           calib_step,
  output logic                           oc_comp_start,
  output logic                           oc_comp_stop,
  output logic                           bus_comp_count_mode,
  output logic [1:0]                     pwm_command,
  output logic                           zero_duty,
  output logic                           pump_timeout
);
  import ipss_pkg::*;

  ipss_cfg_t    cfg;
  ipss_item_t   item;
  ipss_result_t res;
  ipss_result_t out_res;
  logic         item_valid;
  logic         advance;
  logic         accept;
  logic         cfg_write;
  logic [1:0]   reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pump_timeout_ticks <= RST_PUMP_TIMEOUT;
      cfg.calibration_ticks  <= RST_CALIB_TICKS;
      cfg.adc_window_low     <= RST_WIN_LOW;
      cfg.adc_window_high    <= RST_WIN_HIGH;
    end else if (cfg_write) begin
      case (reg_index)
        REG_PUMP_TIMEOUT: cfg.pump_timeout_ticks <= pwdata[CFG_TICK_BITS-1:0];
        REG_CALIB_TICKS:  cfg.calibration_ticks  <= pwdata[CFG_TICK_BITS-1:0];
        REG_WIN_LOW:      cfg.adc_window_low  <= ADC_BITS'(pwdata[CFG_WIN_BITS-1:0]);
        REG_WIN_HIGH:     cfg.adc_window_high <= ADC_BITS'(pwdata[CFG_WIN_BITS-1:0]);
        default:          cfg.pump_timeout_ticks <= cfg.pump_timeout_ticks;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_PUMP_TIMEOUT: prdata = DATA_BITS'(cfg.pump_timeout_ticks);
      REG_CALIB_TICKS:  prdata = DATA_BITS'(cfg.calibration_ticks);
      REG_WIN_LOW:      prdata = DATA_BITS'(cfg.adc_window_low);
      REG_WIN_HIGH:     prdata = DATA_BITS'(cfg.adc_window_high);
      default:          prdata = '0;
    endcase
  end

  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.mode           <= mode;
      item.adc_u          <= adc_u;
      item.adc_v          <= adc_v;
      item.adc_w          <= adc_w;
      item.bus_comp_fault <= bus_comp_fault;
    end
  end

  ipss_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (item),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign phase               = out_res.phase;
  assign pump_init           = out_res.pump_init;
  assign pump_pulse          = out_res.pump_pulse;
  assign pump_release        = out_res.pump_release;
  assign calib_begin         = out_res.calib_begin;
  assign calib_step          = out_res.calib_step;
  assign oc_comp_start       = out_res.oc_comp_start;
  assign oc_comp_stop        = out_res.oc_comp_stop;
  assign bus_comp_count_mode = out_res.bus_comp_count_mode;
  assign pwm_command         = out_res.pwm_command;
  assign zero_duty           = out_res.zero_duty;
  assign pump_timeout        = out_res.pump_timeout;

endmodule

@@ src/ipss_checker.sv @@
// Port-level checks for the start-up sequencer, bound to the top level.
// Depends on ipss_pkg and inverter_pwm_startup_sequencer_top.
module ipss_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] phase,
  input logic       pump_init,
  input logic [1:0] pwm_command,
  input logic       pump_timeout
);
  import ipss_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(phase) && $stable(pwm_command))
    else $error("result changed while stalled");

  a_timeout_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && pump_timeout |-> phase == PH_FAULT)
    else $error("pump timeout without fault phase");

  a_pwm_off_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid && pwm_command == PWM_DISABLE |-> phase == PH_STOP)
    else $error("PWM disable outside stop phase");

  a_init_pumping: assert property (@(posedge clk) disable iff (rst)
    out_valid && pump_init |-> phase == PH_PUMPING)
    else $error("pump init without entering pumping");

endmodule

bind inverter_pwm_startup_sequencer_top ipss_checker u_ipss_checker (.*);

@@ tb/sv/ipss_sequence_checker.sv @@
// Checker for the inverter PWM start-up sequencer: watches the APB writes and both
// item channels, predicts every result transfer and compares it field by field.
// Depends on ipss_pkg.
module ipss_sequence_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [ipss_pkg::ADDR_BITS-1:0] paddr,
  input  logic [ipss_pkg::DATA_BITS-1:0] pwdata,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [1:0]                     mode,
  input  logic [ipss_pkg::ADC_BITS-1:0]  adc_u,
  input  logic [ipss_pkg::ADC_BITS-1:0]  adc_v,
  input  logic [ipss_pkg::ADC_BITS-1:0]  adc_w,
  input  logic                           bus_comp_fault,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [3:0]                     phase,
  input  logic                           pump_init,
  input  logic                           pump_pulse,
  input  logic                           pump_release,
  input  logic                           calib_begin,
  input  logic                           calib_step,
  input  logic                           oc_comp_start,
  input  logic                           oc_comp_stop,
  input  logic                           bus_comp_count_mode,
  input  logic [1:0]                     pwm_command,
  input  logic                           zero_duty,
  input  logic                           pump_timeout,
  output int                             mismatch_count,
  output int                             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import ipss_pkg::*;

  localparam int REPORT_CAP = 100;

  ipss_cfg_t               cfg;
  logic [3:0]              seq_phase;
  logic [TIMER_BITS-1:0]   seq_timer;
  logic                    start_req;
  logic                    stop_req;
  ipss_result_t            predicted_strobes[$];
  ipss_item_t              taken;
  ipss_result_t            want;
  ipss_result_t            got;

  initial begin
    mismatch_count = 0;
    outstanding    = 0;
  end

  function automatic logic in_window(logic [ADC_BITS-1:0] v);
    return (cfg.adc_window_low < v) && (v < cfg.adc_window_high);
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      if (mismatch_count < REPORT_CAP)
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  task automatic bump_timer();
    if (seq_timer != '1)
      seq_timer = seq_timer + 1'b1;
  endtask

  task automatic step_sequencer(input ipss_item_t it, output ipss_result_t r);
    logic ok;
    r  = '0;
    ok = in_window(it.adc_u) && in_window(it.adc_v) && in_window(it.adc_w);
    case (it.mode)
      MODE_START: begin
        start_req = 1'b1;
        stop_req  = 1'b0;
      end
      MODE_STOP: begin
        stop_req  = 1'b1;
        start_req = 1'b0;
      end
      MODE_TICK: begin
        case (seq_phase)
          PH_STOP: begin
            if (start_req) begin
              start_req = 1'b0;
              seq_phase = PH_PUMP_SETUP;
            end
            r.oc_comp_stop = 1'b1;
            stop_req       = 1'b0;
            seq_timer      = '0;
          end
          PH_PUMP_SETUP: begin
            r.pump_init = 1'b1;
            seq_phase   = PH_PUMPING;
          end
          PH_PUMPING: begin
            if (ok) begin
              seq_timer     = '0;
              seq_phase     = PH_CALIBRATE;
              r.calib_begin = 1'b1;
            end else begin
              bump_timer();
              if (seq_timer > cfg.pump_timeout_ticks) begin
                seq_phase      = PH_FAULT;
                r.pump_timeout = 1'b1;
              end else if (it.bus_comp_fault) begin
                seq_phase = PH_FAULT;
              end else begin
                r.pump_pulse = 1'b1;
              end
            end
          end
          PH_CALIBRATE: begin
            if (stop_req) begin
              stop_req              = 1'b0;
              seq_phase             = PH_STOP;
              r.bus_comp_count_mode = 1'b1;
            end else begin
              bump_timer();
              if (seq_timer > cfg.calibration_ticks)
                seq_phase = PH_COMP_SETUP;
              r.calib_step = 1'b1;
              if (it.bus_comp_fault)
                seq_phase = PH_FAULT;
              else
                r.pump_pulse = 1'b1;
            end
          end
          PH_COMP_SETUP: begin
            if (!ok) begin
              seq_phase = PH_FAULT;
            end else begin
              r.bus_comp_count_mode = 1'b1;
              r.pump_release        = 1'b1;
              r.oc_comp_start       = 1'b1;
              r.pwm_command         = PWM_ENABLE;
              seq_phase             = PH_PRESTART;
              seq_timer             = '0;
            end
          end
          PH_PRESTART: begin
            bump_timer();
            if (seq_timer > cfg.calibration_ticks)
              seq_phase = PH_START;
            r.zero_duty  = 1'b1;
            r.calib_step = 1'b1;
          end
          PH_START: begin
            r.pwm_command = PWM_ENABLE;
            seq_phase     = PH_RUN;
          end
          PH_RUN: begin
            if (stop_req) begin
              stop_req      = 1'b0;
              seq_phase     = PH_STOP;
              r.pwm_command = PWM_DISABLE;
            end
          end
          PH_FAULT: begin
            r.pump_release = 1'b1;
            if (stop_req) begin
              stop_req              = 1'b0;
              seq_phase             = PH_STOP;
              r.bus_comp_count_mode = 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    r.phase = seq_phase;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg.pump_timeout_ticks = RST_PUMP_TIMEOUT;
      cfg.calibration_ticks  = RST_CALIB_TICKS;
      cfg.adc_window_low     = RST_WIN_LOW;
      cfg.adc_window_high    = RST_WIN_HIGH;
      seq_phase = PH_STOP;
      seq_timer = '0;
      start_req = 1'b0;
      stop_req  = 1'b0;
      predicted_strobes.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_PUMP_TIMEOUT: cfg.pump_timeout_ticks = pwdata[CFG_TICK_BITS-1:0];
          REG_CALIB_TICKS:  cfg.calibration_ticks  = pwdata[CFG_TICK_BITS-1:0];
          REG_WIN_LOW:      cfg.adc_window_low     = pwdata[ADC_BITS-1:0];
          REG_WIN_HIGH:     cfg.adc_window_high    = pwdata[ADC_BITS-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{phase, pump_init, pump_pulse, pump_release, calib_begin, calib_step,
                oc_comp_start, oc_comp_stop, bus_comp_count_mode, pwm_command,
                zero_duty, pump_timeout};
        if (predicted_strobes.size() == 0) begin
          if (mismatch_count < REPORT_CAP)
            $error("result transfer with nothing expected, phase %0d", phase);
          mismatch_count++;
        end else begin
          want = predicted_strobes.pop_front();
          check_field("phase", want.phase, got.phase);
          check_field("pump_init", want.pump_init, got.pump_init);
          check_field("pump_pulse", want.pump_pulse, got.pump_pulse);
          check_field("pump_release", want.pump_release, got.pump_release);
          check_field("calib_begin", want.calib_begin, got.calib_begin);
          check_field("calib_step", want.calib_step, got.calib_step);
          check_field("oc_comp_start", want.oc_comp_start, got.oc_comp_start);
          check_field("oc_comp_stop", want.oc_comp_stop, got.oc_comp_stop);
          check_field("bus_comp_count_mode", want.bus_comp_count_mode,
                      got.bus_comp_count_mode);
          check_field("pwm_command", want.pwm_command, got.pwm_command);
          check_field("zero_duty", want.zero_duty, got.zero_duty);
          check_field("pump_timeout", want.pump_timeout, got.pump_timeout);
        end
      end
      if (in_valid && !in_stall) begin
        taken = '{mode, adc_u, adc_v, adc_w, bus_comp_fault};
        step_sequencer(taken, want);
        predicted_strobes.push_back(want);
      end
    end
    outstanding = predicted_strobes.size();
  end

endmodule

@@ tb/sv/inverter_pwm_startup_sequencer_top_test.sv @@
// Testbench top for the inverter PWM start-up sequencer: clock, reset, APB set-up,
// directed and random item stimulus with sender gaps and receiver stalls, verdict.
// Depends on ipss_pkg, inverter_pwm_startup_sequencer_top and ipss_sequence_checker.
module inverter_pwm_startup_sequencer_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ipss_pkg::*;

  localparam logic [1:0]          MODE_UNUSED = 2'd3;
  localparam logic [ADC_BITS-1:0] ADC_MID     = ADC_BITS'(2048);
  localparam logic [ADC_BITS-1:0] ADC_TOP     = '1;
  localparam int                  NUM_SETS    = 7;
  localparam int                  RAND_PER_SET = 105;
  localparam int                  CLOSED_TICKS = 40;

  typedef enum int {FLOW_FREE, FLOW_SEND_GAPS, FLOW_RECV_STALLS, FLOW_BOTH} flow_t;

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           mode;
  logic [ADC_BITS-1:0]  adc_u;
  logic [ADC_BITS-1:0]  adc_v;
  logic [ADC_BITS-1:0]  adc_w;
  logic                 bus_comp_fault;
  logic                 out_valid;
  logic                 out_stall;
  logic [3:0]           phase;
  logic                 pump_init;
  logic                 pump_pulse;
  logic                 pump_release;
  logic                 calib_begin;
  logic                 calib_step;
  logic                 oc_comp_start;
  logic                 oc_comp_stop;
  logic                 bus_comp_count_mode;
  logic [1:0]           pwm_command;
  logic                 zero_duty;
  logic                 pump_timeout;
  int                   mismatch_count;
  int                   outstanding;

  flow_t flow;
  int    win_lo;
  int    win_hi;

  int unsigned set_timeout[NUM_SETS] = '{5, 0, 20, 8, 65534, 3, 12};
  int unsigned set_calib[NUM_SETS]   = '{3, 0, 10, 6, 65534, 65534, 4};
  int unsigned set_lo[NUM_SETS]      = '{100, 0, 2000, 1000, 4095, 0, 50};
  int unsigned set_hi[NUM_SETS]      = '{3995, 4095, 2001, 3000, 0, 4095, 4000};

  inverter_pwm_startup_sequencer_top dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
    .adc_u(adc_u), .adc_v(adc_v), .adc_w(adc_w), .bus_comp_fault(bus_comp_fault),
    .out_valid(out_valid), .out_stall(out_stall), .phase(phase),
    .pump_init(pump_init), .pump_pulse(pump_pulse), .pump_release(pump_release),
    .calib_begin(calib_begin), .calib_step(calib_step),
    .oc_comp_start(oc_comp_start), .oc_comp_stop(oc_comp_stop),
    .bus_comp_count_mode(bus_comp_count_mode), .pwm_command(pwm_command),
    .zero_duty(zero_duty), .pump_timeout(pump_timeout)
  );

  ipss_sequence_checker checker_i (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
    .adc_u(adc_u), .adc_v(adc_v), .adc_w(adc_w), .bus_comp_fault(bus_comp_fault),
    .out_valid(out_valid), .out_stall(out_stall), .phase(phase),
    .pump_init(pump_init), .pump_pulse(pump_pulse), .pump_release(pump_release),
    .calib_begin(calib_begin), .calib_step(calib_step),
    .oc_comp_start(oc_comp_start), .oc_comp_stop(oc_comp_stop),
    .bus_comp_count_mode(bus_comp_count_mode), .pwm_command(pwm_command),
    .zero_duty(zero_duty), .pump_timeout(pump_timeout),
    .mismatch_count(mismatch_count), .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(negedge clk) begin
    case (flow)
      FLOW_RECV_STALLS: out_stall <= ($urandom_range(99) < 46);
      FLOW_BOTH:        out_stall <= ($urandom_range(99) < 24);
      default:          out_stall <= 1'b0;
    endcase
  end

  function automatic logic sender_gap();
    case (flow)
      FLOW_SEND_GAPS: return $urandom_range(99) < 46;
      FLOW_BOTH:      return $urandom_range(99) < 24;
      default:        return 1'b0;
    endcase
  endfunction

  task automatic write_reg(logic [1:0] idx, int unsigned value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_BITS'({idx, 2'b00});
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic program_regs(int unsigned tmo, int unsigned cal, int unsigned lo,
                              int unsigned hi);
    write_reg(REG_PUMP_TIMEOUT, tmo);
    write_reg(REG_CALIB_TICKS, cal);
    write_reg(REG_WIN_LOW, lo);
    write_reg(REG_WIN_HIGH, hi);
    win_lo = lo;
    win_hi = hi;
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (outstanding != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send(logic [1:0] m, logic [ADC_BITS-1:0] u, logic [ADC_BITS-1:0] v,
                      logic [ADC_BITS-1:0] w, logic f);
    while (sender_gap()) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    mode           = m;
    adc_u          = u;
    adc_v          = v;
    adc_w          = w;
    bus_comp_fault = f;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic tick(logic [ADC_BITS-1:0] u = ADC_MID, logic [ADC_BITS-1:0] v = ADC_MID,
                      logic [ADC_BITS-1:0] w = ADC_MID, logic f = 1'b0);
    send(MODE_TICK, u, v, w, f);
  endtask

  function automatic logic [ADC_BITS-1:0] pick_adc();
    if (win_lo + 1 < win_hi && $urandom_range(99) < 85)
      return ADC_BITS'($urandom_range(win_hi - 1, win_lo + 1));
    return ADC_BITS'($urandom);
  endfunction

  task automatic send_random();
    int          roll;
    logic [1:0]  m;
    roll = $urandom_range(99);
    if (roll < 88)
      m = MODE_TICK;
    else if (roll < 94)
      m = MODE_START;
    else if (roll < 99)
      m = MODE_STOP;
    else
      m = MODE_UNUSED;
    send(m, pick_adc(), pick_adc(), pick_adc(), $urandom_range(99) < 3);
  endtask

  initial begin
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid       = 1'b0;
    mode           = MODE_TICK;
    adc_u          = '0;
    adc_v          = '0;
    adc_w          = '0;
    bus_comp_fault = 1'b0;
    out_stall      = 1'b0;
    flow           = FLOW_FREE;
    win_lo         = RST_WIN_LOW;
    win_hi         = RST_WIN_HIGH;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    program_regs(2, 1, 100, 3995);
    send(MODE_UNUSED, '0, '0, '0, 1'b0);
    tick();
    send(MODE_STOP, ADC_TOP, ADC_TOP, ADC_TOP, 1'b1);
    send(MODE_START, '0, '0, '0, 1'b0);
    tick();
    tick();
    tick(12'd100, ADC_MID, ADC_MID);
    tick(12'd101, 12'd3994, ADC_MID, 1'b1);
    tick();
    tick();
    tick();
    tick();
    tick();
    tick();
    tick();
    send(MODE_STOP, '0, '0, '0, 1'b0);
    tick();
    send(MODE_START, '0, '0, '0, 1'b0);
    tick();
    tick();
    tick('0, '0, '0);
    tick(ADC_TOP, ADC_TOP, 12'd3995, 1'b1);
    tick();
    send(MODE_STOP, '0, '0, '0, 1'b0);
    tick();
    send(MODE_START, '0, '0, '0, 1'b0);
    tick();
    tick();
    tick('0, '0, '0);
    tick('0, '0, '0);
    tick('0, '0, '0);
    send(MODE_STOP, '0, '0, '0, 1'b0);
    tick();

    for (int s = 0; s < NUM_SETS; s++) begin
      wait_drained();
      program_regs(set_timeout[s], set_calib[s], set_lo[s], set_hi[s]);
      flow = flow_t'(s % 4);
      if (set_timeout[s] == 65534 && set_lo[s] + 1 >= set_hi[s]) begin
        // pumping with the window closed
        send(MODE_START, '0, '0, '0, 1'b0);
        tick();
        tick();
        repeat (CLOSED_TICKS)
          tick(ADC_BITS'($urandom), ADC_BITS'($urandom), ADC_BITS'($urandom), 1'b0);
        tick();
        send(MODE_STOP, '0, '0, '0, 1'b0);
        tick();
      end
      repeat (RAND_PER_SET) begin
        if ($urandom_range(99) == 0)
          wait_drained();
        send_random();
      end
    end

    flow = FLOW_FREE;
    wait_drained();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && outstanding == 0)
      $display("inverter_pwm_startup_sequencer_top_test: clean");
    else
      $display("inverter_pwm_startup_sequencer_top_test: errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("inverter_pwm_startup_sequencer_top_test: errors");
    $finish;
  end

endmodule
